// File: hdl/display_window_gram_port_unit_macros.svh
// Assertion macros used by the back end of the display window frame memory port unit.
`ifndef DISPLAY_WINDOW_GRAM_PORT_UNIT_MACROS_SVH
`define DISPLAY_WINDOW_GRAM_PORT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DWGP_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DWGP_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: hdl/dwgp_pkg.sv
// Types and constants of the display window frame memory port unit.
`default_nettype none
package dwgp_pkg;

	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned PANEL_IDX_W = 12;
	localparam int unsigned DEF_PANEL_WIDTH = 800;
	localparam int unsigned DEF_PANEL_HEIGHT = 480;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] OPC_COMMAND = 2'd0;
	localparam logic [1:0] OPC_DATA_WRITE = 2'd1;
	localparam logic [1:0] OPC_DATA_READ = 2'd2;

	localparam logic [7:0] CMD_COLUMN = 8'h2A;
	localparam logic [7:0] CMD_ROW = 8'h2B;
	localparam logic [7:0] CMD_WRITE = 8'h2C;
	localparam logic [7:0] CMD_READ = 8'h2E;
	localparam logic [15:0] BYTE_MASK = 16'h00FF;

	localparam logic [2:0] PIDX_START_HI = 3'd0;
	localparam logic [2:0] PIDX_START_LO = 3'd1;
	localparam logic [2:0] PIDX_END_HI = 3'd2;
	localparam logic [2:0] PIDX_END_LO = 3'd3;
	localparam logic [2:0] PIDX_DONE = 3'd4;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_WRITE,
		ACC_READ
	} access_kind_t;

	typedef struct packed {
		access_kind_t         kind;
		logic                 hit;
		logic [PIXEL_W-1:0]   pixel;
		logic [COORD_W-1:0]   column;
		logic [COORD_W-1:0]   row;
	} op_t;

endpackage
`default_nettype wire

// File: hdl/dwgp_front.sv
// Front end: decodes bus requests, holds window and cursor, builds memory operations.
`default_nettype none
module dwgp_front #(
	parameter int unsigned PANEL_WIDTH = dwgp_pkg::DEF_PANEL_WIDTH,
	parameter int unsigned PANEL_HEIGHT = dwgp_pkg::DEF_PANEL_HEIGHT,
	parameter int unsigned ADDR_W = 19
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    opcode,
	input  wire logic [dwgp_pkg::PIXEL_W-1:0]  bus_value,
	output dwgp_pkg::op_t                      op,
	output logic [ADDR_W-1:0]                  addr
);
	import dwgp_pkg::*;

	localparam int unsigned PROD_W = 2 * PANEL_IDX_W + 1;

	logic [7:0]          cmd_q;
	logic [2:0]          pidx_q;
	logic [COORD_W-1:0]  col_start_q, col_end_q, row_start_q, row_end_q;
	logic [COORD_W-1:0]  col_q, row_q;

	logic [7:0]          cmd_d;
	logic [2:0]          pidx_d;
	logic [COORD_W-1:0]  col_start_d, col_end_d, row_start_d, row_end_d;
	logic [COORD_W-1:0]  col_d, row_d;
	logic [COORD_W-1:0]  adv_col, adv_row;
	logic [COORD_W-1:0]  pbyte;
	logic                in_panel;
	logic [PROD_W-1:0]   lin_addr;
	access_kind_t        kind;

	assign pbyte = bus_value & BYTE_MASK;
	assign in_panel = (32'(col_q) < PANEL_WIDTH) && (32'(row_q) < PANEL_HEIGHT);
	assign lin_addr = PROD_W'(row_q[PANEL_IDX_W-1:0]) * PROD_W'(PANEL_WIDTH)
		+ PROD_W'(col_q[PANEL_IDX_W-1:0]);
	assign addr = lin_addr[ADDR_W-1:0];

	always_comb begin
		if (col_q >= col_end_q) begin
			adv_col = col_start_q;
			adv_row = (row_q >= row_end_q) ? row_start_q : row_q + 16'd1;
		end else begin
			adv_col = col_q + 16'd1;
			adv_row = row_q;
		end
	end

	always_comb begin
		logic [COORD_W-1:0] s_val, e_val;
		cmd_d = cmd_q;
		pidx_d = pidx_q;
		col_start_d = col_start_q;
		col_end_d = col_end_q;
		row_start_d = row_start_q;
		row_end_d = row_end_q;
		col_d = col_q;
		row_d = row_q;
		kind = ACC_NONE;
		s_val = (cmd_q == CMD_COLUMN) ? col_start_q : row_start_q;
		e_val = (cmd_q == CMD_COLUMN) ? col_end_q : row_end_q;
		case (pidx_q)
			PIDX_START_HI: s_val = {pbyte[7:0], s_val[7:0]};
			PIDX_START_LO: s_val = {s_val[15:8], pbyte[7:0]};
			PIDX_END_HI:   e_val = {pbyte[7:0], e_val[7:0]};
			PIDX_END_LO:   e_val = {e_val[15:8], pbyte[7:0]};
			default: ;
		endcase
		unique case (opcode)
			OPC_COMMAND: begin
				cmd_d = bus_value[7:0];
				pidx_d = PIDX_START_HI;
				if (bus_value[7:0] == CMD_WRITE || bus_value[7:0] == CMD_READ) begin
					col_d = col_start_q;
					row_d = row_start_q;
				end
			end
			OPC_DATA_WRITE: begin
				if (cmd_q == CMD_COLUMN || cmd_q == CMD_ROW) begin
					if (cmd_q == CMD_COLUMN) begin
						col_start_d = s_val;
						col_end_d = e_val;
					end else begin
						row_start_d = s_val;
						row_end_d = e_val;
					end
					if (pidx_q < PIDX_DONE)
						pidx_d = pidx_q + 3'd1;
				end else if (cmd_q == CMD_WRITE) begin
					kind = ACC_WRITE;
					col_d = adv_col;
					row_d = adv_row;
				end
			end
			OPC_DATA_READ: begin
				if (cmd_q == CMD_READ) begin
					kind = ACC_READ;
					col_d = adv_col;
					row_d = adv_row;
				end
			end
			default: ;
		endcase
	end

	assign op.kind = kind;
	assign op.hit = in_panel;
	assign op.pixel = bus_value;
	assign op.column = col_d;
	assign op.row = row_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			pidx_q <= '0;
			col_start_q <= '0;
			col_end_q <= COORD_W'(PANEL_WIDTH - 1);
			row_start_q <= '0;
			row_end_q <= COORD_W'(PANEL_HEIGHT - 1);
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			cmd_q <= cmd_d;
			pidx_q <= pidx_d;
			col_start_q <= col_start_d;
			col_end_q <= col_end_d;
			row_start_q <= row_start_d;
			row_end_q <= row_end_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/dwgp_queue.sv
// Short queue of memory operations between front and back end.
`default_nettype none
module dwgp_queue #(
	parameter int unsigned ADDR_W = 19,
	parameter int unsigned DEPTH = dwgp_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dwgp_pkg::op_t      push_op,
	input  wire logic [ADDR_W-1:0]  push_addr,
	input  wire logic               pop,
	output dwgp_pkg::op_t           head_op,
	output logic [ADDR_W-1:0]       head_addr,
	output logic                    empty,
	output logic                    full
);
	import dwgp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	op_t                ops_q [DEPTH];
	logic [ADDR_W-1:0]  addrs_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign head_op = ops_q[rd_ptr_q];
	assign head_addr = addrs_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ops_q[wr_ptr_q] <= push_op;
			addrs_q[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hdl/dwgp_back.sv
// Back end: frame memory access and result register.
`default_nettype none
`include "display_window_gram_port_unit_macros.svh"
module dwgp_back #(
	parameter int unsigned PANEL_WIDTH = dwgp_pkg::DEF_PANEL_WIDTH,
	parameter int unsigned PANEL_HEIGHT = dwgp_pkg::DEF_PANEL_HEIGHT,
	parameter int unsigned ADDR_W = 19
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop,
	input  wire dwgp_pkg::op_t                 op,
	input  wire logic [ADDR_W-1:0]             addr,
	output logic                               done,
	output logic [dwgp_pkg::PIXEL_W-1:0]       read_pixel,
	output logic                               read_valid,
	output logic [dwgp_pkg::COORD_W-1:0]       cursor_column,
	output logic [dwgp_pkg::COORD_W-1:0]       cursor_row
);
	import dwgp_pkg::*;

	localparam int unsigned MEM_DEPTH = PANEL_WIDTH * PANEL_HEIGHT;

	logic [PIXEL_W-1:0]  mem [MEM_DEPTH];
	logic [PIXEL_W-1:0]  rdata_q;
	logic                done_s1, rhit_s1;
	logic [COORD_W-1:0]  col_s1, row_s1;

	always_ff @(posedge clk) begin
		if (pop && op.kind == ACC_WRITE && op.hit)
			mem[addr] <= op.pixel;
		if (pop && op.kind == ACC_READ && op.hit)
			rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			rhit_s1 <= 1'b0;
		end else begin
			done_s1 <= pop;
			rhit_s1 <= pop && op.kind == ACC_READ && op.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			col_s1 <= op.column;
			row_s1 <= op.row;
		end
	end

	assign done = done_s1;
	assign read_valid = done_s1 && rhit_s1;
	assign read_pixel = read_valid ? rdata_q : '0;
	assign cursor_column = col_s1;
	assign cursor_row = row_s1;

	`DWGP_ASSERT_NXT(a_pop_gives_done, pop, done)
	`DWGP_ASSERT_NXT(a_write_no_valid, pop && op.kind != ACC_READ, !read_valid)
	`DWGP_ASSERT_IMP(a_zero_unless_valid, !read_valid, read_pixel == '0)

endmodule
`default_nettype wire

// File: hdl/display_window_gram_port_unit.sv
// An accepted request is written into the operation queue, then the back end registers its result strobe.
// Throughput: one request per cycle; the back end drains the operation queue every cycle.
// busy never rises: the queue holds at most one operation, so it cannot fill.
// Reset clears command, window, cursor and queue; frame memory holds no reset value.
// The receiver cannot stall: each result is shown for one cycle with done high.
`default_nettype none
module display_window_gram_port_unit #(
	parameter int unsigned PANEL_WIDTH = dwgp_pkg::DEF_PANEL_WIDTH,
	parameter int unsigned PANEL_HEIGHT = dwgp_pkg::DEF_PANEL_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    opcode,
	input  wire logic [dwgp_pkg::PIXEL_W-1:0]  bus_value,
	output logic                               done,
	output logic [dwgp_pkg::PIXEL_W-1:0]       read_pixel,
	output logic                               read_valid,
	output logic [dwgp_pkg::COORD_W-1:0]       cursor_column,
	output logic [dwgp_pkg::COORD_W-1:0]       cursor_row
);
	import dwgp_pkg::*;

	localparam int unsigned MEM_DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic               accept, q_empty, q_full, pop;
	op_t                f_op, h_op;
	logic [ADDR_W-1:0]  f_addr, h_addr;

	assign busy = q_full;
	assign accept = start && !q_full;
	assign pop = !q_empty;

	dwgp_front #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.ADDR_W(ADDR_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.opcode(opcode),
		.bus_value(bus_value),
		.op(f_op),
		.addr(f_addr)
	);

	dwgp_queue #(
		.ADDR_W(ADDR_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_op(f_op),
		.push_addr(f_addr),
		.pop(pop),
		.head_op(h_op),
		.head_addr(h_addr),
		.empty(q_empty),
		.full(q_full)
	);

	dwgp_back #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.ADDR_W(ADDR_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop(pop),
		.op(h_op),
		.addr(h_addr),
		.done(done),
		.read_pixel(read_pixel),
		.read_valid(read_valid),
		.cursor_column(cursor_column),
		.cursor_row(cursor_row)
	);

endmodule
`default_nettype wire

// File: test/display_window_gram_port_unit_tb.sv
// Self-checking testbench for the display window frame memory port unit.
`default_nettype none
module display_window_gram_port_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dwgp_pkg::*;

	localparam int unsigned PANEL_W = DEF_PANEL_WIDTH;
	localparam int unsigned PANEL_H = DEF_PANEL_HEIGHT;
	localparam logic [1:0] OPC_NOP = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               read_valid;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} bus_reply_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = OPC_COMMAND;
	logic [PIXEL_W-1:0] bus_value = '0;
	logic busy;
	logic done;
	logic [PIXEL_W-1:0] read_pixel;
	logic read_valid;
	logic [COORD_W-1:0] cursor_column;
	logic [COORD_W-1:0] cursor_row;

	logic [7:0] last_command = 8'h00;
	logic [2:0] param_slot = PIDX_START_HI;
	logic [15:0] col_first = 16'd0;
	logic [15:0] col_last = 16'(PANEL_W - 1);
	logic [15:0] row_first = 16'd0;
	logic [15:0] row_last = 16'(PANEL_H - 1);
	logic [15:0] cur_col = 16'd0;
	logic [15:0] cur_row = 16'd0;
	logic [15:0] written_pixels [int unsigned];

	bus_reply_t bus_replies_due [$];
	bus_reply_t oldest_reply;
	int unsigned failures = 0;
	int unsigned requests_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 0;

	display_window_gram_port_unit #(
		.PANEL_WIDTH(PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.bus_value(bus_value),
		.done(done),
		.read_pixel(read_pixel),
		.read_valid(read_valid),
		.cursor_column(cursor_column),
		.cursor_row(cursor_row)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit cursor_in_panel();
		return cur_col < PANEL_W && cur_row < PANEL_H;
	endfunction

	function automatic int unsigned pixel_address();
		return int'(cur_row) * PANEL_W + int'(cur_col);
	endfunction

	function automatic bit read_is_defined();
		if (last_command != CMD_READ || !cursor_in_panel())
			return 1'b1;
		return written_pixels.exists(pixel_address());
	endfunction

	function automatic int unsigned span_length(input logic [15:0] lo, input logic [15:0] hi);
		if (hi < lo)
			return 1;
		if (hi - lo >= 16'd8)
			return 8;
		return int'(hi - lo) + 1;
	endfunction

	task automatic step_cursor();
		if (cur_col >= col_last) begin
			cur_col = col_first;
			if (cur_row >= row_last)
				cur_row = row_first;
			else
				cur_row = cur_row + 16'd1;
		end else begin
			cur_col = cur_col + 16'd1;
		end
	endtask

	task automatic store_window_byte(inout logic [15:0] lo, inout logic [15:0] hi,
			input logic [7:0] b);
		case (param_slot)
			PIDX_START_HI: lo[15:8] = b;
			PIDX_START_LO: lo[7:0] = b;
			PIDX_END_HI: hi[15:8] = b;
			PIDX_END_LO: hi[7:0] = b;
			default: ;
		endcase
		if (param_slot < PIDX_DONE)
			param_slot = param_slot + 3'd1;
	endtask

	task automatic apply_bus_access(input logic [1:0] op, input logic [15:0] val,
			output bus_reply_t reply);
		logic [7:0] b;
		b = 8'(val & BYTE_MASK);
		reply = '0;
		case (op)
			OPC_COMMAND: begin
				last_command = b;
				param_slot = PIDX_START_HI;
				if (b == CMD_WRITE || b == CMD_READ) begin
					cur_col = col_first;
					cur_row = row_first;
				end
			end
			OPC_DATA_WRITE: begin
				if (last_command == CMD_COLUMN) begin
					store_window_byte(col_first, col_last, b);
				end else if (last_command == CMD_ROW) begin
					store_window_byte(row_first, row_last, b);
				end else if (last_command == CMD_WRITE) begin
					if (cursor_in_panel())
						written_pixels[pixel_address()] = val;
					step_cursor();
				end
			end
			OPC_DATA_READ: begin
				if (last_command == CMD_READ) begin
					if (cursor_in_panel()) begin
						reply.read_valid = 1'b1;
						if (written_pixels.exists(pixel_address()))
							reply.pixel = written_pixels[pixel_address()];
					end
					step_cursor();
				end
			end
			default: ;
		endcase
		reply.column = cur_col;
		reply.row = cur_row;
	endtask

	task automatic send_request(input logic [1:0] op, input logic [15:0] val);
		logic [1:0] kind;
		bus_reply_t reply;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		kind = op;
		// never read a pixel that was not written
		if (kind == OPC_DATA_READ && !read_is_defined())
			kind = OPC_NOP;
		start <= 1'b1;
		opcode <= kind;
		bus_value <= val;
		do @(posedge clk); while (busy !== 1'b0);
		apply_bus_access(kind, val, reply);
		bus_replies_due.push_back(reply);
		requests_sent++;
	endtask

	task automatic send_command(input logic [7:0] code);
		send_request(OPC_COMMAND, {8'($urandom), code});
	endtask

	task automatic wait_for_replies();
		start <= 1'b0;
		do @(posedge clk); while (bus_replies_due.size() != 0);
	endtask

	task automatic send_window(input logic [7:0] code, input logic [15:0] lo,
			input logic [15:0] hi);
		logic [7:0] bytes [4];
		int unsigned count;
		int unsigned sel;
		bytes = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
		count = 4;
		sel = $urandom_range(9);
		if (sel == 0)
			count = $urandom_range(3, 1);
		else if (sel == 1)
			count = $urandom_range(6, 5);
		send_command(code);
		for (int i = 0; i < count; i++)
			send_request(OPC_DATA_WRITE, {8'($urandom), (i < 4) ? bytes[i] : 8'($urandom)});
	endtask

	task automatic pick_span(input int unsigned extent, input int unsigned max_len,
			output logic [15:0] lo, output logic [15:0] hi);
		int unsigned kind;
		int unsigned len;
		kind = $urandom_range(9);
		len = $urandom_range(max_len);
		if (kind < 7) begin
			lo = 16'($urandom_range(extent - 8));
			hi = lo + 16'(len);
		end else if (kind == 7) begin
			lo = 16'(extent - 1 - $urandom_range(4));
			hi = lo + 16'(1 + len);
		end else if (kind == 8) begin
			hi = 16'($urandom_range(extent - 8));
			lo = hi + 16'(1 + $urandom_range(5));
		end else begin
			lo = 16'($urandom);
			hi = 16'($urandom);
		end
	endtask

	task automatic run_noise_burst();
		logic [1:0] op;
		logic [15:0] val;
		repeat ($urandom_range(10, 3)) begin
			op = 2'($urandom);
			val = 16'($urandom);
			if (op == OPC_COMMAND && $urandom_range(1) == 1) begin
				case ($urandom_range(3))
					0: val[7:0] = CMD_COLUMN;
					1: val[7:0] = CMD_ROW;
					2: val[7:0] = CMD_WRITE;
					default: val[7:0] = CMD_READ;
				endcase
			end
			send_request(op, val);
		end
	endtask

	task automatic run_window_burst();
		logic [15:0] c_lo;
		logic [15:0] c_hi;
		logic [15:0] r_lo;
		logic [15:0] r_hi;
		int unsigned pixels;
		pick_span(PANEL_W, 7, c_lo, c_hi);
		pick_span(PANEL_H, 3, r_lo, r_hi);
		if ($urandom_range(9) != 0)
			send_window(CMD_COLUMN, c_lo, c_hi);
		if ($urandom_range(9) != 0)
			send_window(CMD_ROW, r_lo, r_hi);
		pixels = span_length(c_lo, c_hi) * span_length(r_lo, r_hi) + $urandom_range(2);
		send_command(CMD_WRITE);
		repeat (pixels) send_request(OPC_DATA_WRITE, 16'($urandom));
		if ($urandom_range(4) == 0)
			run_noise_burst();
		send_command(CMD_READ);
		repeat (pixels) send_request(OPC_DATA_READ, 16'($urandom));
	endtask

	task automatic test_ignored_accesses();
		send_request(OPC_NOP, 16'hFFFF);
		send_request(OPC_DATA_READ, 16'h0000);
		send_request(OPC_DATA_WRITE, 16'hFFFF);
		send_request(OPC_COMMAND, 16'h00E0);
		send_request(OPC_DATA_WRITE, 16'h1234);
	endtask

	task automatic test_panel_edge_window();
		send_request(OPC_COMMAND, 16'hFF00 | CMD_COLUMN);
		send_request(OPC_DATA_WRITE, 16'hFF03);
		send_request(OPC_DATA_WRITE, 16'h001F);
		send_request(OPC_DATA_WRITE, 16'hA503);
		send_request(OPC_DATA_WRITE, 16'h0020);
		send_request(OPC_COMMAND, 16'h0000 | CMD_ROW);
		send_request(OPC_DATA_WRITE, 16'h0001);
		send_request(OPC_DATA_WRITE, 16'h00DF);
		send_request(OPC_DATA_WRITE, 16'h0001);
		send_request(OPC_DATA_WRITE, 16'h00E0);
		send_request(OPC_DATA_WRITE, 16'hFFFF);
		send_request(OPC_COMMAND, 16'h0000 | CMD_WRITE);
		send_request(OPC_DATA_WRITE, 16'hFFFF);
		send_request(OPC_DATA_WRITE, 16'h0000);
		send_request(OPC_DATA_WRITE, 16'h5A5A);
		send_request(OPC_DATA_WRITE, 16'hA5A5);
		send_request(OPC_COMMAND, 16'h0000 | CMD_READ);
		repeat (5) send_request(OPC_DATA_READ, 16'hFFFF);
	endtask

	task automatic test_random_windows(input int unsigned idle_pct, input int unsigned count);
		int unsigned target;
		sender_idle_pct = idle_pct;
		target = requests_sent + count;
		while (requests_sent < target) begin
			if ($urandom_range(9) < 7)
				run_window_burst();
			else
				run_noise_burst();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (bus_replies_due.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				failures++;
			end else begin
				oldest_reply = bus_replies_due.pop_front();
				if (read_pixel !== oldest_reply.pixel) begin
					$display("%0t: read_pixel expected %h, actual %h", $time,
						oldest_reply.pixel, read_pixel);
					failures++;
				end
				if (read_valid !== oldest_reply.read_valid) begin
					$display("%0t: read_valid expected %b, actual %b", $time,
						oldest_reply.read_valid, read_valid);
					failures++;
				end
				if (cursor_column !== oldest_reply.column) begin
					$display("%0t: cursor_column expected %0d, actual %0d", $time,
						oldest_reply.column, cursor_column);
					failures++;
				end
				if (cursor_row !== oldest_reply.row) begin
					$display("%0t: cursor_row expected %0d, actual %0d", $time,
						oldest_reply.row, cursor_row);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				bus_replies_due.size());
			$display("display_window_gram_port_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 35;
		test_ignored_accesses();
		wait_for_replies();
		test_panel_edge_window();
		wait_for_replies();
		test_random_windows(35, 160);
		wait_for_replies();
		test_random_windows(56, 160);
		wait_for_replies();
		test_random_windows(0, 160);
		wait_for_replies();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("display_window_gram_port_unit test passed");
		else
			$display("display_window_gram_port_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire
